// File: hdl/aacb_pkg.sv
// Shared constants and types of the antialiased circle coverage blend.
`timescale 1ns / 1ps
`default_nettype none
package aacb_pkg;
   localparam int DEF_SUBSAMPLES = 6;
   localparam int DEF_MAX_RADIUS = 255;
   localparam int OFFSET_W = 10;
   localparam int RADIUS_W = 8;
   localparam int THICK_W = 8;
   localparam int COLOR_W = 32;
   localparam int CHAN_W = 8;
   localparam int RGB_W = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RADIUS     = 2'd0,
      CSR_THICKNESS  = 2'd1,
      CSR_DRAW_COLOR = 2'd2,
      CSR_RING_MODE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic ring_mode;
      logic active;
   } geom_ctrl_type;
endpackage
`default_nettype wire

// File: hdl/aacb_cfg.sv
// Configuration registers and the derived squared radius bounds.
`timescale 1ns / 1ps
`default_nettype none
module aacb_cfg
   import aacb_pkg::*;
#(
   parameter int SUBSAMPLES_PER_AXIS = DEF_SUBSAMPLES,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   output geom_ctrl_type               ctrl,
   output logic [2*(RADIUS_W+$clog2(SUBSAMPLES_PER_AXIS+1))-1:0] ro2,
   output logic [2*(RADIUS_W+$clog2(SUBSAMPLES_PER_AXIS+1))-1:0] ri2,
   output logic [COLOR_W-1:0]          draw_color
);
   localparam int ROS_W = RADIUS_W + $clog2(SUBSAMPLES_PER_AXIS + 1);
   localparam int R2_W = 2 * ROS_W;
   localparam int RO_CAP = (MAX_RADIUS < 255) ? MAX_RADIUS : 255;
   localparam logic [RADIUS_W-1:0] RoCapV = RADIUS_W'(RO_CAP);
   localparam logic [ROS_W-1:0] SubV = ROS_W'(SUBSAMPLES_PER_AXIS);

   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [THICK_W-1:0]  thickness_ff, thickness_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic                ring_ff, ring_in;

   logic [RADIUS_W-1:0] ro, ri;
   logic [RADIUS_W:0]   diff;
   logic [ROS_W-1:0]    ros_ff, ros_in, ris_ff, ris_in;
   logic [R2_W-1:0]     ro2_ff, ro2_in, ri2_ff, ri2_in;
   logic                act1_ff, act1_in, act2_ff;

   always_comb begin
      radius_in = radius_ff;
      thickness_in = thickness_ff;
      color_in = color_ff;
      ring_in = ring_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_RADIUS: begin
               radius_in = csr_write_data[RADIUS_W-1:0];
            end
            CSR_THICKNESS: begin
               thickness_in = csr_write_data[THICK_W-1:0];
            end
            CSR_DRAW_COLOR: begin
               color_in = csr_write_data[COLOR_W-1:0];
            end
            CSR_RING_MODE: begin
               ring_in = csr_write_data[0];
            end
            default: begin
               ring_in = ring_ff;
            end
         endcase
      end
   end

   always_comb begin
      ro = (radius_ff > RoCapV) ? RoCapV : radius_ff;
      diff = {1'b0, ro} - {1'b0, thickness_ff};
      ri = (diff[RADIUS_W] || diff == '0) ? RADIUS_W'(1) : diff[RADIUS_W-1:0];
      ros_in = ROS_W'(ro) * SubV;
      ris_in = ROS_W'(ri) * SubV;
      ro2_in = R2_W'(ros_ff) * R2_W'(ros_ff);
      ri2_in = R2_W'(ris_ff) * R2_W'(ris_ff);
      act1_in = (ro != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         thickness_ff <= THICK_W'(1);
         color_ff <= '0;
         ring_ff <= 1'b0;
         ros_ff <= '0;
         ris_ff <= '0;
         ro2_ff <= '0;
         ri2_ff <= '0;
         act1_ff <= 1'b0;
         act2_ff <= 1'b0;
      end else begin
         radius_ff <= radius_in;
         thickness_ff <= thickness_in;
         color_ff <= color_in;
         ring_ff <= ring_in;
         ros_ff <= ros_in;
         ris_ff <= ris_in;
         ro2_ff <= ro2_in;
         ri2_ff <= ri2_in;
         act1_ff <= act1_in;
         act2_ff <= act1_ff;
      end
   end

   assign ctrl.ring_mode = ring_ff;
   assign ctrl.active = act2_ff;
   assign ro2 = ro2_ff;
   assign ri2 = ri2_ff;
   assign draw_color = color_ff;
endmodule
`default_nettype wire

// File: hdl/aacb_hits.sv
// Subsample coordinates, squares and inside tests, four pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
module aacb_hits
   import aacb_pkg::*;
#(
   parameter int SUBSAMPLES_PER_AXIS = DEF_SUBSAMPLES
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic signed [OFFSET_W-1:0] offset_x,
   input  wire logic signed [OFFSET_W-1:0] offset_y,
   input  wire logic [COLOR_W-1:0]         background,
   input  wire geom_ctrl_type              ctrl,
   input  wire logic [2*(RADIUS_W+$clog2(SUBSAMPLES_PER_AXIS+1))-1:0] ro2,
   input  wire logic [2*(RADIUS_W+$clog2(SUBSAMPLES_PER_AXIS+1))-1:0] ri2,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [SUBSAMPLES_PER_AXIS*SUBSAMPLES_PER_AXIS-1:0] hits,
   output logic [RGB_W-1:0]                out_background
);
   localparam int SUB = SUBSAMPLES_PER_AXIS;
   localparam int NST = 4;
   localparam int PX_W = OFFSET_W + $clog2(SUB) + 1;
   localparam int SQ_W = 2 * (PX_W - 1);
   localparam int SQE_W = SQ_W + 1;
   localparam int R2_W = 2 * (RADIUS_W + $clog2(SUB + 1));
   localparam int CMP_W = (SQ_W + 1 > R2_W) ? SQ_W + 1 : R2_W;
   localparam logic signed [PX_W-1:0] SubS = PX_W'(SUB);

   logic [NST-1:0] v_ff;
   logic [NST-1:0] en;

   logic signed [OFFSET_W-1:0] ox_ff, oy_ff;
   logic [RGB_W-1:0]           bg0_ff, bg1_ff, bg2_ff, bg3_ff;
   logic signed [PX_W-1:0]     px_ff [SUB], px_in [SUB];
   logic signed [PX_W-1:0]     py_ff [SUB], py_in [SUB];
   logic [SQ_W-1:0]            sqx_ff [SUB], sqx_in [SUB];
   logic [SQ_W-1:0]            sqy_ff [SUB], sqy_in [SUB];
   logic [SUB*SUB-1:0]         hit_ff, hit_in;

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || out_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      logic signed [PX_W-1:0]  oxe, oye;
      logic signed [SQE_W-1:0] ex, ey, prx, pry;
      logic [CMP_W-1:0]        d2;
      oxe = PX_W'(ox_ff);
      oye = PX_W'(oy_ff);
      for (int i = 0; i < SUB; i++) begin
         px_in[i] = oxe * SubS + PX_W'(i + 1);
         py_in[i] = oye * SubS + PX_W'(i + 1);
      end
      for (int i = 0; i < SUB; i++) begin
         ex = SQE_W'(px_ff[i]);
         ey = SQE_W'(py_ff[i]);
         prx = ex * ex;
         pry = ey * ey;
         sqx_in[i] = prx[SQ_W-1:0];
         sqy_in[i] = pry[SQ_W-1:0];
      end
      for (int j = 0; j < SUB; j++) begin
         for (int i = 0; i < SUB; i++) begin
            d2 = CMP_W'(sqx_ff[i]) + CMP_W'(sqy_ff[j]);
            hit_in[j*SUB+i] = ctrl.active && (d2 <= CMP_W'(ro2)) &&
                              (!ctrl.ring_mode || d2 >= CMP_W'(ri2));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ox_ff <= offset_x;
         oy_ff <= offset_y;
         bg0_ff <= background[RGB_W-1:0];
      end
      if (en[1]) begin
         px_ff <= px_in;
         py_ff <= py_in;
         bg1_ff <= bg0_ff;
      end
      if (en[2]) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         bg2_ff <= bg1_ff;
      end
      if (en[3]) begin
         hit_ff <= hit_in;
         bg3_ff <= bg2_ff;
      end
   end

   assign in_ready = en[0];
   assign out_valid = v_ff[NST-1];
   assign hits = hit_ff;
   assign out_background = bg3_ff;
endmodule
`default_nettype wire

// File: hdl/aacb_cover.sv
// Coverage count: per-row popcount, then the row sum, two pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
module aacb_cover
   import aacb_pkg::*;
#(
   parameter int SUBSAMPLES_PER_AXIS = DEF_SUBSAMPLES
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [SUBSAMPLES_PER_AXIS*SUBSAMPLES_PER_AXIS-1:0] hits,
   input  wire logic [RGB_W-1:0]    in_background,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [$clog2(SUBSAMPLES_PER_AXIS*SUBSAMPLES_PER_AXIS+1)-1:0] cov,
   output logic [RGB_W-1:0]         out_background
);
   localparam int SUB = SUBSAMPLES_PER_AXIS;
   localparam int NST = 2;
   localparam int ROW_W = $clog2(SUB + 1);
   localparam int COV_W = $clog2(SUB * SUB + 1);

   logic [NST-1:0]   v_ff;
   logic [NST-1:0]   en;
   logic [ROW_W-1:0] row_ff [SUB], row_in [SUB];
   logic [COV_W-1:0] cov_ff, cov_in;
   logic [RGB_W-1:0] bg0_ff, bg1_ff;

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || out_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      for (int j = 0; j < SUB; j++) begin
         row_in[j] = '0;
         for (int i = 0; i < SUB; i++) begin
            row_in[j] = row_in[j] + ROW_W'(hits[j*SUB+i]);
         end
      end
      cov_in = '0;
      for (int j = 0; j < SUB; j++) begin
         cov_in = cov_in + COV_W'(row_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         if (en[1]) begin
            v_ff[1] <= v_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         row_ff <= row_in;
         bg0_ff <= in_background;
      end
      if (en[1]) begin
         cov_ff <= cov_in;
         bg1_ff <= bg0_ff;
      end
   end

   assign in_ready = en[0];
   assign out_valid = v_ff[NST-1];
   assign cov = cov_ff;
   assign out_background = bg1_ff;
endmodule
`default_nettype wire

// File: hdl/aacb_blend.sv
// Per-channel blend by coverage with reciprocal division, output register last.
`timescale 1ns / 1ps
`default_nettype none
module aacb_blend
   import aacb_pkg::*;
#(
   parameter int SUBSAMPLES_PER_AXIS = DEF_SUBSAMPLES
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [$clog2(SUBSAMPLES_PER_AXIS*SUBSAMPLES_PER_AXIS+1)-1:0] cov,
   input  wire logic [RGB_W-1:0]    in_background,
   input  wire logic [COLOR_W-1:0]  draw_color,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic                     write_enable,
   output logic [COLOR_W-1:0]       pixel_out
);
   localparam int SUB = SUBSAMPLES_PER_AXIS;
   localparam int NST = 3;
   localparam int NSUB = SUB * SUB;
   localparam int COV_W = $clog2(NSUB + 1);
   localparam int NCH = RGB_W / CHAN_W;
   localparam int NUM_W = $clog2(((1 << CHAN_W) - 1) * NSUB + 1);
   localparam int SHIFT = NUM_W;
   localparam int RCP_W = SHIFT + 1;
   localparam int PRD_W = NUM_W + RCP_W;
   localparam int RECIP = (2 ** SHIFT) / NSUB;
   localparam logic [COV_W-1:0] NCov = COV_W'(NSUB);
   localparam logic [NUM_W-1:0] NNum = NUM_W'(NSUB);
   localparam logic [PRD_W-1:0] RecipV = PRD_W'(RECIP);

   logic [NST-1:0] v_ff;
   logic [NST-1:0] en;

   logic [NUM_W-1:0]  num0_ff [NCH], num0_in [NCH], num1_ff [NCH];
   logic [CHAN_W-1:0] q_ff [NCH], q_in [NCH];
   logic              full0_ff, full1_ff, empty0_ff, empty1_ff;
   logic              we_ff, we_in;
   logic [COLOR_W-1:0] pix_ff, pix_in;

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || out_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      logic [COV_W-1:0]  inv;
      logic [PRD_W-1:0]  prod;
      logic [NUM_W-1:0]  rem;
      logic [CHAN_W-1:0] q;
      logic [RGB_W-1:0]  rgb;
      inv = NCov - cov;
      for (int c = 0; c < NCH; c++) begin
         num0_in[c] = NUM_W'(draw_color[c*CHAN_W +: CHAN_W]) * NUM_W'(cov) +
                      NUM_W'(in_background[c*CHAN_W +: CHAN_W]) * NUM_W'(inv);
      end
      for (int c = 0; c < NCH; c++) begin
         prod = PRD_W'(num0_ff[c]) * RecipV;
         q_in[c] = prod[SHIFT +: CHAN_W];
      end
      rgb = '0;
      for (int c = 0; c < NCH; c++) begin
         rem = num1_ff[c] - NUM_W'(q_ff[c]) * NNum;
         q = q_ff[c] + CHAN_W'(rem >= NNum);
         rgb[c*CHAN_W +: CHAN_W] = q;
      end
      we_in = !empty1_ff;
      if (empty1_ff) begin
         pix_in = '0;
      end else if (full1_ff) begin
         pix_in = draw_color;
      end else begin
         pix_in = COLOR_W'(rgb);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         num0_ff <= num0_in;
         full0_ff <= (cov == NCov);
         empty0_ff <= (cov == '0);
      end
      if (en[1]) begin
         q_ff <= q_in;
         num1_ff <= num0_ff;
         full1_ff <= full0_ff;
         empty1_ff <= empty0_ff;
      end
      if (en[2]) begin
         we_ff <= we_in;
         pix_ff <= pix_in;
      end
   end

   assign in_ready = en[0];
   assign out_valid = v_ff[NST-1];
   assign write_enable = we_ff;
   assign pixel_out = pix_ff;
endmodule
`default_nettype wire

// File: hdl/aa_circle_ring_coverage_blend.sv
// Throughput: one transaction per clock while the output does not stall; nine
// register stages with per-stage valid bits, and a stalled output only holds
// stages that are occupied. Reset: clears all valid bits and sets radius 0,
// thickness 1, draw color 0, disc mode; after a register write the squared bounds
// pass through the scaled radius registers and then the squared registers.
`timescale 1ns / 1ps
`default_nettype none
module aa_circle_ring_coverage_blend
   import aacb_pkg::*;
#(
   parameter int SUBSAMPLES_PER_AXIS = DEF_SUBSAMPLES,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [OFFSET_W-1:0] req_offset_x,
   input  wire logic signed [OFFSET_W-1:0] req_offset_y,
   input  wire logic [COLOR_W-1:0]         req_background,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_write_enable,
   output logic [COLOR_W-1:0]              rsp_pixel_out,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_write_data
);
   localparam int SUB = SUBSAMPLES_PER_AXIS;
   localparam int R2_W = 2 * (RADIUS_W + $clog2(SUB + 1));
   localparam int COV_W = $clog2(SUB * SUB + 1);

   geom_ctrl_type      ctrl;
   logic [R2_W-1:0]    ro2, ri2;
   logic [COLOR_W-1:0] draw_color;

   logic               hit_valid, hit_ready;
   logic [SUB*SUB-1:0] hits;
   logic [RGB_W-1:0]   hit_bg;
   logic               cov_valid, cov_ready;
   logic [COV_W-1:0]   cov;
   logic [RGB_W-1:0]   cov_bg;

   aacb_cfg #(
      .SUBSAMPLES_PER_AXIS(SUBSAMPLES_PER_AXIS),
      .MAX_RADIUS(MAX_RADIUS)
   ) u_cfg (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .ctrl(ctrl),
      .ro2(ro2),
      .ri2(ri2),
      .draw_color(draw_color)
   );

   aacb_hits #(
      .SUBSAMPLES_PER_AXIS(SUBSAMPLES_PER_AXIS)
   ) u_hits (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_ready(req_ready),
      .offset_x(req_offset_x),
      .offset_y(req_offset_y),
      .background(req_background),
      .ctrl(ctrl),
      .ro2(ro2),
      .ri2(ri2),
      .out_valid(hit_valid),
      .out_ready(hit_ready),
      .hits(hits),
      .out_background(hit_bg)
   );

   aacb_cover #(
      .SUBSAMPLES_PER_AXIS(SUBSAMPLES_PER_AXIS)
   ) u_cover (
      .clock(clock),
      .reset(reset),
      .in_valid(hit_valid),
      .in_ready(hit_ready),
      .hits(hits),
      .in_background(hit_bg),
      .out_valid(cov_valid),
      .out_ready(cov_ready),
      .cov(cov),
      .out_background(cov_bg)
   );

   aacb_blend #(
      .SUBSAMPLES_PER_AXIS(SUBSAMPLES_PER_AXIS)
   ) u_blend (
      .clock(clock),
      .reset(reset),
      .in_valid(cov_valid),
      .in_ready(cov_ready),
      .cov(cov),
      .in_background(cov_bg),
      .draw_color(draw_color),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .write_enable(rsp_write_enable),
      .pixel_out(rsp_pixel_out)
   );
endmodule
`default_nettype wire
